FILE: rtl/core/fwrv_pkg.sv
// fwrv_pkg: shared widths, request and status codes, and cell control type
// for the FIFO with remove-by-value. No dependencies.
`default_nettype none

package fwrv_pkg;

  // Default storage depth, in entries
  localparam int DEPTH_DEF = 128;

  // Field widths
  localparam int VALUE_W  = 32;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 7;
  localparam int CNT_W    = 8;
  localparam int CAP_W    = 8;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

  // Request codes; the unused code behaves as a search
  localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic cmp_en;  // latch the compare against the incoming key
    logic shift;   // take the neighbor's value (gap close on remove)
    logic wr;      // load the pushed value
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/fwrv_cell.sv
// fwrv_cell: one storage slot of the queue with its own key comparator.
// Depends on fwrv_pkg.
`default_nettype none

module fwrv_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire fwrv_pkg::cell_ctrl_t        ctrl,
  input  wire logic                        occ,       // slot holds a live entry
  input  wire logic [fwrv_pkg::VALUE_W-1:0] key_cmp,
  input  wire logic [fwrv_pkg::VALUE_W-1:0] key_wr,
  input  wire logic [fwrv_pkg::VALUE_W-1:0] next_data, // neighbor toward tail
  output logic      [fwrv_pkg::VALUE_W-1:0] data,
  output logic                             match
);

  logic [fwrv_pkg::VALUE_W-1:0] data_r;
  logic                         match_r;

  // Slot value: push load wins, else shift from neighbor
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      data_r <= key_wr;
    end else if (ctrl.shift) begin
      data_r <= next_data;
    end
  end

  // Registered compare, qualified by occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctrl.cmp_en) begin
      match_r <= occ && (data_r == key_cmp);
    end
  end

  assign data  = data_r;
  assign match = match_r;

endmodule

`default_nettype wire

FILE: rtl/core/fwrv_prio.sv
// fwrv_prio: first-match resolution over the cell match bits: found flag,
// index of the lowest match and the mask of cells at or above it. No deps.
`default_nettype none

module fwrv_prio #(
  parameter int DEPTH = 128
) (
  input  wire logic [DEPTH-1:0]         match,
  output logic                          found,
  output logic [$clog2(DEPTH)-1:0]      pos,
  output logic [DEPTH-1:0]              mask_ge
);

  localparam int IW = $clog2(DEPTH);

  logic [DEPTH-1:0] neg;
  logic [DEPTH-1:0] lowest;

  // Two's complement isolates the lowest set bit and everything above it
  assign neg     = ~match + DEPTH'(1);
  assign lowest  = match & neg;
  assign mask_ge = match | neg;
  assign found   = |match;

  // One-hot to index
  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (lowest[i]) begin
        pos = pos | IW'(i);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fifo_with_remove_by_value.sv
// fifo_with_remove_by_value: ordered queue of 32-bit values with push,
// remove-first-match and search. Depends on fwrv_pkg, fwrv_cell, fwrv_prio.
//
// Usage:
//   Input channel (in_valid/in_ready) carries a request: in_req_type selects
//   push (0), remove first match (1) or search (2, code 3 acts as search),
//   in_value is the key. Output channel (out_valid/out_ready) returns one
//   item per request: status, found flag, position and the entry count
//   after the request.
//   Storage is a row of DEPTH cells, each with its own comparator. On the
//   accept edge every cell compares against the key; in the S_EXEC state the
//   first match is resolved, and once the output register is free the cells
//   at and above it shift one place toward the head (remove), or the tail
//   cell loads the key (push); the result is registered in the same update.
//   A new request is taken only in S_IDLE, once the previous one has passed
//   the compare and the resolve/update on the shared cell row.
//   The capacity register (cfg_wr_en/cfg_wr_data) limits pushes; values
//   above DEPTH saturate at DEPTH. Write it only while the block is idle.
//   Reset empties the queue and sets capacity to 100; cell contents are not
//   cleared. If the receiver stalls, the finished item holds in the output
//   register, the next request may still be taken and is held until the
//   output slot frees.
`default_nettype none

module fifo_with_remove_by_value #(
  parameter int DEPTH = fwrv_pkg::DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Request channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [fwrv_pkg::REQ_W-1:0]          in_req_type,
  input  wire logic signed [fwrv_pkg::VALUE_W-1:0] in_value,
  // Result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [fwrv_pkg::STATUS_W-1:0]            out_status,
  output logic                                     out_found,
  output logic [fwrv_pkg::POS_W-1:0]               out_position,
  output logic [fwrv_pkg::CNT_W-1:0]               out_entry_count,
  // Capacity register
  input  wire logic                                cfg_wr_en,
  input  wire logic [fwrv_pkg::CAP_W-1:0]          cfg_wr_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > fwrv_pkg::CAP_W) ? CW : fwrv_pkg::CAP_W;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                         state_r;
  logic [fwrv_pkg::REQ_W-1:0]     kind_r;
  logic [fwrv_pkg::VALUE_W-1:0]   key_r;
  logic [CW-1:0]                  count_r;
  logic [CW-1:0]                  count_nxt;
  logic [fwrv_pkg::CAP_W-1:0]     cap_r;
  logic                           out_valid_r;
  logic [fwrv_pkg::STATUS_W-1:0]  out_status_r;
  logic                           out_found_r;
  logic [fwrv_pkg::POS_W-1:0]     out_position_r;
  logic [fwrv_pkg::CNT_W-1:0]     out_entry_count_r;

  fwrv_pkg::cell_ctrl_t           ctrl   [DEPTH];
  logic [fwrv_pkg::VALUE_W-1:0]   cdata  [DEPTH];
  logic [DEPTH-1:0]               match;
  logic [DEPTH-1:0]               mask_ge;
  logic                           hit;
  logic [IW-1:0]                  hit_pos;

  logic                           accept;
  logic                           fire;
  logic                           is_push;
  logic                           is_rm;
  logic                           push_ok;
  logic [fwrv_pkg::STATUS_W-1:0]  res_status;
  logic                           res_found;
  logic [IW-1:0]                  res_pos;

  // Handshake
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fire     = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  // Request decode and limit check (capacity saturates at DEPTH)
  assign is_push = (kind_r == fwrv_pkg::REQ_PUSH);
  assign is_rm   = (kind_r == fwrv_pkg::REQ_REMOVE);
  assign push_ok = is_push && (LW'(count_r) < LW'(cap_r)) && (count_r < CW'(DEPTH));

  // Cell row
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [fwrv_pkg::VALUE_W-1:0] nbr;

    if (g == DEPTH - 1) begin : g_last
      assign nbr = cdata[g];
    end else begin : g_mid
      assign nbr = cdata[g+1];
    end

    assign ctrl[g].cmp_en = accept;
    assign ctrl[g].shift  = fire && is_rm && hit && mask_ge[g];
    assign ctrl[g].wr     = fire && push_ok && (count_r == CW'(g));

    fwrv_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl[g]),
      .occ       (CW'(g) < count_r),
      .key_cmp   (in_value),
      .key_wr    (key_r),
      .next_data (nbr),
      .data      (cdata[g]),
      .match     (match[g])
    );
  end

  // First-match resolution
  fwrv_prio #(.DEPTH(DEPTH)) u_prio (
    .match   (match),
    .found   (hit),
    .pos     (hit_pos),
    .mask_ge (mask_ge)
  );

  // Result and next count
  always_comb begin
    res_status = fwrv_pkg::ST_DONE;
    res_found  = 1'b0;
    res_pos    = '0;
    count_nxt  = count_r;
    if (is_push) begin
      if (push_ok) begin
        res_pos   = count_r[IW-1:0];
        count_nxt = count_r + CW'(1);
      end else begin
        res_status = fwrv_pkg::ST_FULL;
      end
    end else if (hit) begin
      res_found = 1'b1;
      res_pos   = hit_pos;
      if (is_rm) begin
        count_nxt = count_r - CW'(1);
      end
    end else begin
      res_status = fwrv_pkg::ST_ABSENT;
    end
  end

  // Sequencer, count, capacity and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= fwrv_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request latch and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_req_type;
      key_r  <= in_value;
    end
    if (fire) begin
      out_status_r      <= res_status;
      out_found_r       <= res_found;
      out_position_r    <= fwrv_pkg::POS_W'(res_pos);
      out_entry_count_r <= fwrv_pkg::CNT_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_position    = out_position_r;
  assign out_entry_count = out_entry_count_r;

  // Count never passes the storage depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  // A successful remove drops the count by one
  a_rm_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_rm && hit) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("remove did not decrement count");

  // A search never changes the count
  a_search_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !is_push && !is_rm) |=> (count_r == $past(count_r)))
    else $error("search changed count");

  // A result only appears after an update cycle
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result without update cycle");

  // Push only writes while below the limit
  a_push_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && push_ok) |-> (LW'(count_r) < LW'(cap_r)))
    else $error("push past capacity");

endmodule

`default_nettype wire
